// File: src/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPIM_ASSERT_IMP(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");

// The consequent must hold starting in the cycle after the antecedent.
`define MPIM_ASSERT_NXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: src/mpim_pkg.sv
package mpim_pkg;

  // Sizes of the tensor description and of the flat indexes.
  localparam int MAX_DIMS = 4;
  localparam int IDX_W    = 24;
  localparam int DIM_W    = 16;

  // Output strides are kept one bit wider than an index. Any stride above the
  // largest index gives quotient zero, so larger products saturate here.
  localparam int OSTR_W   = IDX_W + 1;
  localparam int BIT_W    = $clog2(IDX_W);
  localparam int DSEL_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W    = $clog2(MAX_DIMS + 1);
  localparam int NDIM_W   = 3;
  localparam int OSZ_W    = DIM_W + 2;

  // Configuration port.
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int SHAPE_W   = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_REFLECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE0  = CFG_IDX_W'(2);

  // Bit positions of the fields inside one shape register.
  localparam int SIZE_LSB  = 0;
  localparam int LEFT_LSB  = 16;
  localparam int RIGHT_LSB = 32;

  // One request in flight through the chain.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] rem;
    logic [IDX_W-1:0] quot;
    logic [IDX_W-1:0] flat;
  } mpim_item_t;

endpackage

// File: src/mpim_if.sv
// Request channel: one flat index into the padded output.
interface mpim_in_if;
  logic                       valid;
  logic                       ready;
  logic [mpim_pkg::IDX_W-1:0] out_index;

  modport source (output valid, output out_index, input ready);
  modport sink (input valid, input out_index, output ready);
endinterface

// Response channel: one flat index into the input tensor.
interface mpim_out_if;
  logic                       valid;
  logic                       ready;
  logic [mpim_pkg::IDX_W-1:0] source_index;

  modport source (output valid, output source_index, input ready);
  modport sink (input valid, input source_index, output ready);
endinterface

// File: src/mpim_div_cell.sv
// One restoring-division step: decides one quotient bit of one dimension.
module mpim_div_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        en_i,
  input  logic [mpim_pkg::OSTR_W-1:0] stride_i,
  input  logic [mpim_pkg::BIT_W-1:0]  bit_i,
  input  mpim_pkg::mpim_item_t        item_i,
  output mpim_pkg::mpim_item_t        item_o
);

  logic [mpim_pkg::IDX_W-1:0] shr;
  logic                       take;
  mpim_pkg::mpim_item_t       item_d;
  mpim_pkg::mpim_item_t       item_q;
  logic                       vld_q;

  // Subtract the shifted stride when it fits into the remainder.
  always_comb begin
    shr    = item_i.rem >> bit_i;
    take   = en_i && ({1'b0, shr} >= stride_i);
    item_d = item_i;
    if (take) begin
      item_d.rem          = item_i.rem - (stride_i[mpim_pkg::IDX_W-1:0] << bit_i);
      item_d.quot[bit_i]  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= item_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  always_comb begin
    item_o     = item_q;
    item_o.vld = vld_q;
  end

endmodule

// File: src/mpim_tail_cell.sv
// End of one dimension: mirrors the coordinate, then adds coordinate times
// input stride to the flat source index.
module mpim_tail_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       en_i,
  input  logic                       off_i,
  input  logic [mpim_pkg::DIM_W-1:0] size_i,
  input  logic [mpim_pkg::DIM_W-1:0] left_i,
  input  logic [mpim_pkg::IDX_W-1:0] istride_i,
  input  mpim_pkg::mpim_item_t       item_i,
  output mpim_pkg::mpim_item_t       item_o
);

  localparam int MW = mpim_pkg::IDX_W + 1;
  localparam int PW = mpim_pkg::DIM_W + mpim_pkg::IDX_W;

  logic [MW-1:0]              p;
  logic [MW-1:0]              lft;
  logic [MW-1:0]              sz;
  logic [MW-1:0]              q;
  logic [MW-1:0]              beyond;
  logic [MW-1:0]              edge_pos;
  logic [MW-1:0]              r;
  logic [mpim_pkg::DIM_W-1:0] coord_d;

  logic                       m_vld_q;
  logic [mpim_pkg::IDX_W-1:0] m_rem_q;
  logic [mpim_pkg::IDX_W-1:0] m_flat_q;
  logic [mpim_pkg::DIM_W-1:0] m_coord_q;

  logic [PW-1:0]              prod;
  logic                       o_vld_q;
  mpim_pkg::mpim_item_t       o_item_q;

  // Fold the padded coordinate back into the input range.
  always_comb begin
    p        = MW'(item_i.quot);
    lft      = MW'(left_i);
    sz       = MW'(size_i);
    q        = p - lft;
    beyond   = q - sz;
    edge_pos = sz - MW'(1) - MW'(off_i);
    r        = '0;
    if (sz == '0) begin
      r = '0;
    end else begin
      if (p < lft) begin
        r = lft + MW'(off_i) - MW'(1) - p;
      end else if (q < sz) begin
        r = q;
      end else if (sz < MW'(1) + MW'(off_i)) begin
        r = '0;
      end else begin
        r = edge_pos - ((beyond < edge_pos) ? beyond : edge_pos);
      end
      if (r > sz - MW'(1)) begin
        r = sz - MW'(1);
      end
    end
    coord_d = en_i ? r[mpim_pkg::DIM_W-1:0] : '0;
  end

  // Mirror stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (adv_i) begin
      m_vld_q <= item_i.vld;
      o_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m_rem_q   <= item_i.rem;
      m_flat_q  <= item_i.flat;
      m_coord_q <= coord_d;
    end
  end

  // Multiply-add stage; the quotient is cleared for the next dimension.
  assign prod = PW'(m_coord_q) * PW'(istride_i);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      o_item_q.vld  <= 1'b0;
      o_item_q.rem  <= m_rem_q;
      o_item_q.quot <= '0;
      o_item_q.flat <= m_flat_q + prod[mpim_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    item_o     = o_item_q;
    item_o.vld = o_vld_q;
  end

endmodule

// File: src/mirror_pad_index_map.sv
// Mirror-pad index map.
// Requests arrive on in_i (out_index, a flat row-major index into the padded
// output tensor); each one gives exactly one response on out_o (source_index,
// the flat index of the input element that it copies). Both channels use a
// valid/ready handshake.
// The index passes a row of cells: per dimension 24 one-bit division cells,
// then a mirror cell and a multiply-add cell. One request is taken every cycle
// unless the output stalls or a configuration write or stride rebuild is under way.
// The last cell is the output register. When the receiver stalls, the whole
// row holds and in_i.ready drops until the response is taken.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i must be made only
// while the block is idle; the block does not enforce this. Each write starts
// a stride rebuild, one dimension a cycle, during which in_i.ready stays low.
// Reset selects symmetric mode with one dimension of size one; the strides
// are valid directly after reset and the row of cells holds no request.
module mirror_pad_index_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpim_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mpim_pkg::CFG_W-1:0]     cfg_data_i,
  mpim_in_if.sink                        in_i,
  mpim_out_if.source                     out_o
);

  localparam int NCELL = mpim_pkg::MAX_DIMS * (mpim_pkg::IDX_W + 1);

  logic                              reflect_q;
  logic [mpim_pkg::NDIM_W-1:0]       dims_q;
  logic [mpim_pkg::SHAPE_W-1:0]      shape_q [mpim_pkg::MAX_DIMS];
  logic [mpim_pkg::OSTR_W-1:0]       ostride_q [mpim_pkg::MAX_DIMS];
  logic [mpim_pkg::IDX_W-1:0]        istride_q [mpim_pkg::MAX_DIMS];
  logic [mpim_pkg::CNT_W-1:0]        cnt_q;
  logic [mpim_pkg::CNT_W-1:0]        cnt_d;
  logic [mpim_pkg::NDIM_W-1:0]       n_eff;
  logic [mpim_pkg::DSEL_W-1:0]       cur;
  logic [mpim_pkg::DSEL_W-1:0]       nxt;
  logic [mpim_pkg::DIM_W-1:0]        nsize;
  logic [mpim_pkg::OSZ_W-1:0]        nosz;
  logic [mpim_pkg::OSTR_W+mpim_pkg::OSZ_W-1:0] oprod;
  logic [mpim_pkg::IDX_W+mpim_pkg::DIM_W-1:0]  iprod;
  logic                              adv;
  mpim_pkg::mpim_item_t              chain [NCELL+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reflect_q <= 1'b0;
      dims_q    <= mpim_pkg::NDIM_W'(1);
      for (int i = 0; i < mpim_pkg::MAX_DIMS; i++) begin
        shape_q[i] <= mpim_pkg::SHAPE_W'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mpim_pkg::CFG_REFLECT) begin
        reflect_q <= cfg_data_i[0];
      end else if (cfg_idx_i == mpim_pkg::CFG_DIMS) begin
        dims_q <= cfg_data_i[mpim_pkg::NDIM_W-1:0];
      end else begin
        for (int i = 0; i < mpim_pkg::MAX_DIMS; i++) begin
          if (cfg_idx_i == mpim_pkg::CFG_SHAPE0 + mpim_pkg::CFG_IDX_W'(i)) begin
            shape_q[i] <= cfg_data_i[mpim_pkg::SHAPE_W-1:0];
          end
        end
      end
    end
  end

  // Number of dimensions in use, clamped to the supported range.
  always_comb begin
    if (dims_q == '0) begin
      n_eff = mpim_pkg::NDIM_W'(1);
    end else if (dims_q > mpim_pkg::NDIM_W'(mpim_pkg::MAX_DIMS)) begin
      n_eff = mpim_pkg::NDIM_W'(mpim_pkg::MAX_DIMS);
    end else begin
      n_eff = dims_q;
    end
  end

  // Stride rebuild: innermost dimension first, one per cycle unless a new write restarts it.
  always_comb begin
    cur   = cnt_q[mpim_pkg::DSEL_W-1:0] - mpim_pkg::DSEL_W'(1);
    nxt   = (int'(cur) == mpim_pkg::MAX_DIMS - 1) ? cur : cur + mpim_pkg::DSEL_W'(1);
    nsize = shape_q[nxt][mpim_pkg::SIZE_LSB +: mpim_pkg::DIM_W];
    nosz  = mpim_pkg::OSZ_W'(nsize)
          + mpim_pkg::OSZ_W'(shape_q[nxt][mpim_pkg::LEFT_LSB +: mpim_pkg::DIM_W])
          + mpim_pkg::OSZ_W'(shape_q[nxt][mpim_pkg::RIGHT_LSB +: mpim_pkg::DIM_W]);
    oprod = $bits(oprod)'(ostride_q[nxt]) * $bits(oprod)'(nosz);
    iprod = $bits(iprod)'(istride_q[nxt]) * $bits(iprod)'(nsize);
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      cnt_d = mpim_pkg::CNT_W'(mpim_pkg::MAX_DIMS);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - mpim_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < mpim_pkg::MAX_DIMS; i++) begin
        ostride_q[i] <= mpim_pkg::OSTR_W'(1);
        istride_q[i] <= mpim_pkg::IDX_W'(1);
      end
    end else begin
      cnt_q <= cnt_d;
      if (cnt_q != '0 && !cfg_we_i) begin
        if (mpim_pkg::NDIM_W'(cur) + mpim_pkg::NDIM_W'(1) >= n_eff) begin
          ostride_q[cur] <= mpim_pkg::OSTR_W'(1);
          istride_q[cur] <= mpim_pkg::IDX_W'(1);
        end else begin
          if (oprod > $bits(oprod)'(1) << mpim_pkg::IDX_W) begin
            ostride_q[cur] <= mpim_pkg::OSTR_W'(1) << mpim_pkg::IDX_W;
          end else begin
            ostride_q[cur] <= oprod[mpim_pkg::OSTR_W-1:0];
          end
          istride_q[cur] <= iprod[mpim_pkg::IDX_W-1:0];
        end
      end
    end
  end

  // Handshake: the whole row moves unless a response waits at the output.
  assign adv        = !chain[NCELL].vld || out_o.ready;
  assign in_i.ready = adv && (cnt_q == '0) && !cfg_we_i;

  always_comb begin
    chain[0].vld  = in_i.valid && in_i.ready;
    chain[0].rem  = in_i.out_index;
    chain[0].quot = '0;
    chain[0].flat = '0;
  end

  // Row of cells, outermost dimension first.
  for (genvar d = 0; d < mpim_pkg::MAX_DIMS; d++) begin : g_dim
    localparam int BASE = d * (mpim_pkg::IDX_W + 1);
    logic used;
    logic div_en;

    assign used   = mpim_pkg::NDIM_W'(d) < n_eff;
    assign div_en = used && (ostride_q[d] != '0);

    for (genvar b = 0; b < mpim_pkg::IDX_W; b++) begin : g_bit
      mpim_div_cell u_div (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .adv_i    (adv),
        .en_i     (div_en),
        .stride_i (ostride_q[d]),
        .bit_i    (mpim_pkg::BIT_W'(mpim_pkg::IDX_W - 1 - b)),
        .item_i   (chain[BASE + b]),
        .item_o   (chain[BASE + b + 1])
      );
    end

    mpim_tail_cell u_tail (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .en_i      (used),
      .off_i     (reflect_q),
      .size_i    (shape_q[d][mpim_pkg::SIZE_LSB +: mpim_pkg::DIM_W]),
      .left_i    (shape_q[d][mpim_pkg::LEFT_LSB +: mpim_pkg::DIM_W]),
      .istride_i (istride_q[d]),
      .item_i    (chain[BASE + mpim_pkg::IDX_W]),
      .item_o    (chain[BASE + mpim_pkg::IDX_W + 1])
    );
  end

  assign out_o.valid        = chain[NCELL].vld;
  assign out_o.source_index = chain[NCELL].flat;

endmodule

// File: src/mpim_checker.sv
`include "assert_macros.svh"

// Port-level checks of the mirror-pad index map.
module mpim_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [mpim_pkg::IDX_W-1:0] source_index_i
);

  // A response that is not taken stays offered.
  `MPIM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A stalled response keeps its value.
  `MPIM_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   $stable(source_index_i))

  // No request is taken in the cycle of a configuration write.
  `MPIM_ASSERT_IMP(a_cfg_block, clk_i, rst_ni, cfg_we_i, !in_ready_i)

  // Requests stay blocked while the strides are rebuilt.
  `MPIM_ASSERT_NXT(a_cfg_rebuild, clk_i, rst_ni, cfg_we_i,
                   !in_ready_i ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)

endmodule

bind mirror_pad_index_map mpim_checker u_mpim_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .source_index_i (out_o.source_index)
);

// File: tb/sv/mpim_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both channels, predicts the source index
// of every request and compares it with the response in arrival order.
module mpim_scoreboard (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpim_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mpim_pkg::CFG_W-1:0]     cfg_data_i,
  mpim_in_if                             req_mon,
  mpim_out_if                            rsp_mon,
  output int                             mismatch_o,
  output int                             pending_o,
  output int                             checked_o
);
  import mpim_pkg::*;

  localparam logic [63:0] STRIDE_CAP = 64'd1 << 40;
  localparam logic [63:0] IDX_MASK   = (64'd1 << IDX_W) - 64'd1;

  // Shadow copy of the configuration registers.
  logic             mode_reflect;
  logic [2:0]       dims_used;
  logic [SHAPE_W-1:0] shape_reg [MAX_DIMS];

  logic [IDX_W-1:0] src_expected [$];

  // Fold one padded coordinate back into the input range of its dimension.
  function automatic logic [63:0] fold_coord(logic [63:0] p, logic [63:0] left,
                                             logic [63:0] size, logic [63:0] off);
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] d;
    logic [63:0] edge_pos;
    if (size == 0) return 0;
    if (p < left) begin
      r = left + off - 1 - p;
    end else begin
      q = p - left;
      if (q < size) begin
        r = q;
      end else begin
        d = q - size;
        if (size < 1 + off) return 0;
        edge_pos = size - 1 - off;
        r = edge_pos - ((d < edge_pos) ? d : edge_pos);
      end
    end
    if (r > size - 1) r = size - 1;
    return r;
  endfunction

  // Split the output index into coordinates, fold each, and rebuild the index.
  function automatic logic [IDX_W-1:0] source_of(logic [IDX_W-1:0] out_idx);
    logic [63:0] ostride [MAX_DIMS];
    logic [63:0] istride [MAX_DIMS];
    logic [63:0] rest;
    logic [63:0] flat;
    logic [63:0] coord;
    logic [63:0] isz;
    logic [63:0] osz;
    logic [63:0] prod;
    logic [SHAPE_W-1:0] r;
    int n;
    int i;
    n = dims_used;
    if (n == 0) n = 1;
    if (n > MAX_DIMS) n = MAX_DIMS;
    ostride[n-1] = 1;
    istride[n-1] = 1;
    for (i = n - 2; i >= 0; i--) begin
      r = shape_reg[i+1];
      isz = 64'(r[15:0]);
      osz = isz + 64'(r[31:16]) + 64'(r[47:32]);
      prod = ostride[i+1] * osz;
      if (prod > STRIDE_CAP) prod = STRIDE_CAP;
      ostride[i] = prod;
      istride[i] = (istride[i+1] * isz) & IDX_MASK;
    end
    rest = 64'(out_idx);
    flat = 0;
    for (i = 0; i < n; i++) begin
      r = shape_reg[i];
      coord = 0;
      if (ostride[i] != 0) begin
        coord = rest / ostride[i];
        rest = rest % ostride[i];
      end
      coord = fold_coord(coord, 64'(r[31:16]), 64'(r[15:0]), 64'(mode_reflect));
      flat = (flat + coord * istride[i]) & IDX_MASK;
    end
    return flat[IDX_W-1:0];
  endfunction

  // Track register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_reflect <= 1'b0;
      dims_used <= 3'd1;
      for (int k = 0; k < MAX_DIMS; k++) shape_reg[k] <= SHAPE_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_REFLECT) begin
        mode_reflect <= cfg_data_i[0];
      end else if (cfg_idx_i == CFG_DIMS) begin
        dims_used <= cfg_data_i[2:0];
      end else if (cfg_idx_i >= CFG_SHAPE0 && cfg_idx_i < CFG_SHAPE0 + MAX_DIMS) begin
        shape_reg[cfg_idx_i - CFG_SHAPE0] <= cfg_data_i[SHAPE_W-1:0];
      end
    end
  end

  // Predict on each accepted request, compare on each accepted response.
  initial begin
    mismatch_o = 0;
    pending_o = 0;
    checked_o = 0;
  end

  always @(posedge clk_i) begin
    logic [IDX_W-1:0] want;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) src_expected.push_back(source_of(req_mon.out_index));
      if (rsp_mon.valid && rsp_mon.ready) begin
        checked_o++;
        if (src_expected.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= 10)
            $display("ERROR: response %h with no request waiting", rsp_mon.source_index);
        end else begin
          want = src_expected.pop_front();
          if (want !== rsp_mon.source_index) begin
            mismatch_o++;
            if (mismatch_o <= 10)
              $display("ERROR: source_index expected %h actual %h", want,
                       rsp_mon.source_index);
          end
        end
      end
      pending_o = src_expected.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mpim_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 120;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  mpim_in_if  req_if ();
  mpim_out_if rsp_if ();

  int mismatches;
  int pending;
  int checked;
  int sent;
  int phases;
  int idle_cycles;
  bit quiet;
  bit long_hold;

  // Shadow of the tensor shape, used to aim indexes inside the output.
  logic [SHAPE_W-1:0] cur_shape [MAX_DIMS];
  logic [2:0]         cur_dims;

  mirror_pad_index_map dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (req_if),
    .out_o     (rsp_if)
  );

  mpim_scoreboard chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_mon   (req_if),
    .rsp_mon   (rsp_if),
    .mismatch_o(mismatches),
    .pending_o (pending),
    .checked_o (checked)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout with %0d responses outstanding", pending);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Response receiver with random stall bursts and one long hold-off.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    wait (rst_ni);
    forever begin
      if (long_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one request, possibly after an idle burst, and wait for acceptance.
  task automatic send_index(logic [IDX_W-1:0] idx);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.out_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  // Wait until every predicted response has arrived, then let the row empty.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the whole register set while the block is idle.
  task automatic configure(logic refl, logic [2:0] dims, logic [SHAPE_W-1:0] s0,
                           logic [SHAPE_W-1:0] s1, logic [SHAPE_W-1:0] s2,
                           logic [SHAPE_W-1:0] s3);
    logic [SHAPE_W-1:0] shp [MAX_DIMS];
    shp = '{s0, s1, s2, s3};
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_REFLECT;
    cfg_data_i <= CFG_W'(refl);
    @(posedge clk_i);
    cfg_idx_i <= CFG_DIMS;
    cfg_data_i <= CFG_W'(dims);
    @(posedge clk_i);
    for (int k = 0; k < MAX_DIMS; k++) begin
      cfg_idx_i <= CFG_SHAPE0 + CFG_IDX_W'(k);
      cfg_data_i <= shp[k];
      cur_shape[k] = shp[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_dims = dims;
    phases++;
  endtask

  // Random shape: mostly small tensors, with pads that overrun the mirror.
  function automatic logic [SHAPE_W-1:0] rand_shape();
    logic [15:0] sz;
    case ($urandom_range(0, 5))
      0: return SHAPE_W'({$urandom, $urandom});
      1: begin
        sz = 16'($urandom_range(0, 2));
        return {16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)), sz};
      end
      default: begin
        sz = 16'($urandom_range(1, 12));
        return {16'($urandom_range(0, 14)), 16'($urandom_range(0, 14)), sz};
      end
    endcase
  endfunction

  // Index aimed inside the padded output where that is possible.
  function automatic logic [IDX_W-1:0] rand_index();
    logic [63:0] total;
    int n;
    n = (cur_dims == 0) ? 1 : ((cur_dims > MAX_DIMS) ? MAX_DIMS : cur_dims);
    total = 1;
    for (int k = 0; k < n; k++)
      total = total * (64'(cur_shape[k][15:0]) + 64'(cur_shape[k][31:16]) +
                       64'(cur_shape[k][47:32]));
    if ($urandom_range(0, 4) == 0 || total == 0 || total > (64'd1 << IDX_W))
      return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, 32'(total - 1)));
  endfunction

  initial begin
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_REFLECT;
    cfg_data_i <= '0;
    req_if.valid <= 1'b0;
    req_if.out_index <= '0;
    sent = 0;
    phases = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    long_hold = 1'b0;
    for (int k = 0; k < MAX_DIMS; k++) cur_shape[k] = SHAPE_W'(1);
    cur_dims = 3'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: every index maps somewhere in a one-element tensor.
    send_index('0);
    send_index(IDX_W'(1));
    send_index('1);
    send_index(IDX_W'(24'hAAAAAA));
    send_index(IDX_W'(24'h555555));
    drain();

    // Reflect, two dimensions, oversized pads, a size-one dimension.
    configure(1'b1, 3'd2, {16'd5, 16'd4, 16'd3}, {16'd2, 16'd2, 16'd1}, '0, '0);
    for (int k = 0; k < 8; k++) send_index(IDX_W'(k * 7));
    send_index('1);
    drain();

    // Dimension count zero, above the maximum, and an inner zero-size dimension.
    configure(1'b0, 3'd0, {16'd3, 16'd3, 16'd4}, '1, '1, '1);
    send_index(IDX_W'(9));
    send_index('1);
    drain();
    configure(1'b1, 3'd7, {16'd1, 16'd1, 16'd2}, '0, {16'd1, 16'd0, 16'd3}, '1);
    send_index('0);
    send_index(IDX_W'(77));
    send_index('1);
    drain();

    // Random phases with random content; the receiver holds off once.
    for (int ph = 0; ph < 22; ph++) begin
      if (ph == 3) long_hold = 1'b1;
      if (ph >= 19) quiet = 1'b1;
      configure(1'($urandom), 3'($urandom_range(0, 7)), rand_shape(), rand_shape(),
                rand_shape(), rand_shape());
      repeat (85) send_index(rand_index());
      drain();
    end

    $display("Covered %0d requests over %0d register settings, %0d responses checked.",
             sent, phases, checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
